/* hw/rtl/gfpe_pkg.sv */
// shared types, constants and the gf(256) multiply for the erasure parity encoder
// no dependencies
package gfpe_pkg;

   localparam int RESULT_CAP  = 8;        // most parity words one column emits
   localparam int SHARD_CNT_W = 5;        // width of the shard count register
   localparam int PAR_CNT_W   = 4;        // width of the parity count register
   localparam int INDEX_W     = 3;        // width of a parity index
   localparam logic [8:0] GF_POLY = 9'h11d;

   // configuration register indexes
   localparam logic CSR_SHARD_TOTAL = 1'b0;
   localparam logic CSR_CHECK_TOTAL = 1'b1;

   typedef struct packed {
      logic                 load;
      logic [INDEX_W-1:0]   last_index;
   } gfpe_load_type;

   typedef struct packed {
      logic valid;
      logic last;
   } gfpe_buf_status_type;

   // carry-less multiply reduced by 0x11d
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ GF_POLY;
         end
      end
      return acc;
   endfunction

endpackage

/* hw/rtl/gfpe_lanes.sv */
// parity lane array: one multiply-accumulate and running power per lane
// depends on gfpe_pkg
module gfpe_lanes
   import gfpe_pkg::*;
#(
   parameter int NUM_LANES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      close,
   input  logic [7:0]                data_byte,
   output logic [NUM_LANES-1:0][7:0] sums_next
);

   logic [NUM_LANES-1:0][7:0] sum_ff;
   logic [NUM_LANES-1:0][7:0] pow_ff;
   logic [NUM_LANES-1:0][7:0] pow_in;

   for (genvar p = 0; p < NUM_LANES; p++) begin : g_lane
      assign sums_next[p] = sum_ff[p] ^ gf_mul(data_byte, pow_ff[p]);
      assign pow_in[p]    = gf_mul(pow_ff[p], 8'(p));

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[p] <= 8'h00;
            pow_ff[p] <= 8'h01;
         end else if (step) begin
            if (close) begin
               sum_ff[p] <= 8'h00;
               pow_ff[p] <= 8'h01;
            end else begin
               sum_ff[p] <= sums_next[p];
               pow_ff[p] <= pow_in[p];
            end
         end
      end
   end

endmodule

/* hw/rtl/gfpe_out_buf.sv */
// result buffer: holds one column of parity words and shifts them out in order
// depends on gfpe_pkg
module gfpe_out_buf
   import gfpe_pkg::*;
#(
   parameter int NUM_LANES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gfpe_load_type             load,
   input  logic [NUM_LANES-1:0][7:0] sums,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_parity_byte,
   output logic [INDEX_W-1:0]        rsp_parity_index,
   output logic                      rsp_last_parity,
   output gfpe_buf_status_type       status
);

   logic [NUM_LANES-1:0][7:0]  data_ff;
   logic                       valid_ff;
   logic [INDEX_W-1:0]         idx_ff;
   logic [INDEX_W-1:0]         last_idx_ff;
   logic                       is_last;
   logic                       take;

   assign is_last = (idx_ff == last_idx_ff);
   assign take    = valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load.load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         last_idx_ff <= load.last_index;
         data_ff     <= sums;
      end else if (take) begin
         for (int i = 0; i < NUM_LANES - 1; i++) begin
            data_ff[i] <= data_ff[i+1];
         end
         data_ff[NUM_LANES-1] <= 8'h00;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_parity_byte  = data_ff[0];
   assign rsp_parity_index = idx_ff;
   assign rsp_last_parity  = is_last;
   assign status.valid     = valid_ff;
   assign status.last      = is_last;

endmodule

/* hw/rtl/gf256_erasure_parity_encoder.sv */
// top level of the gf(256) erasure parity encoder
// depends on gfpe_pkg, gfpe_lanes and gfpe_out_buf
//
// The encoder takes one data byte a cycle while req_stall is low, byte d of a column coming
// from data shard d, and accumulates parity lane p as the sum of data[d] times p^d in
// GF(256), polynomial 0x11d (lane 0 thus repeats data[0]). A word is held in the input
// register and folded into all lanes in parallel as it leaves, so a new word is taken every
// cycle unless a closing word is held back. The word that closes a column also copies the
// lane sums into the result buffer and clears the lanes; the buffer then sends one word per
// parity lane in use, the last one flagged. A closing word waits in the input register until
// the buffer has sent the last word of the previous column. Zero register values count as
// one; values above the build limits saturate. The user must write the registers only while
// the block is idle; the block itself does not enforce this.
module gf256_erasure_parity_encoder
   import gfpe_pkg::*;
#(
   parameter int MAX_DATA   = 16,
   parameter int MAX_PARITY = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // input words
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   // parity words
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_parity_byte,
   output logic [INDEX_W-1:0]     rsp_parity_index,
   output logic                   rsp_last_parity,
   // configuration
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [SHARD_CNT_W-1:0] csr_wdata
);

   // lanes past the emit cap never reach the output
   localparam int NUM_LANES = (MAX_PARITY < RESULT_CAP) ? MAX_PARITY : RESULT_CAP;
   localparam logic [7:0]           MAX_DATA_B = 8'(MAX_DATA);
   localparam logic [PAR_CNT_W-1:0] PAR_CAP    = PAR_CNT_W'(NUM_LANES);

   // configuration registers
   logic [SHARD_CNT_W-1:0] shard_total_ff;
   logic [PAR_CNT_W-1:0]   check_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_total_ff <= SHARD_CNT_W'(16);
         check_total_ff <= PAR_CNT_W'(4);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SHARD_TOTAL: shard_total_ff <= csr_wdata;
            CSR_CHECK_TOTAL: check_total_ff <= csr_wdata[PAR_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective counts after the zero and saturation rules
   logic [SHARD_CNT_W-1:0] nd;
   logic [PAR_CNT_W-1:0]   np;

   always_comb begin
      nd = shard_total_ff;
      if (nd == '0) begin
         nd = SHARD_CNT_W'(1);
      end
      if ({3'b000, nd} > MAX_DATA_B) begin
         nd = MAX_DATA_B[SHARD_CNT_W-1:0];
      end
      np = check_total_ff;
      if (np == '0) begin
         np = PAR_CNT_W'(1);
      end
      if (np > PAR_CAP) begin
         np = PAR_CAP;
      end
   end

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       in_load;

   // shard counter and column close
   logic [SHARD_CNT_W-1:0] shard_cnt_ff;
   logic                   closing;
   logic                   buf_free;
   gfpe_buf_status_type    buf_status;
   gfpe_load_type          buf_load;

   assign closing = ({1'b0, shard_cnt_ff} + 1'b1) >= {1'b0, nd};

   // buffer is free now or frees at this edge with its last word taken
   assign buf_free = !buf_status.valid || (buf_status.last && !rsp_stall);

   assign advance   = in_valid_ff && (!closing || buf_free);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_cnt_ff <= '0;
      end else if (advance) begin
         shard_cnt_ff <= closing ? '0 : shard_cnt_ff + 1'b1;
      end
   end

   logic [NUM_LANES-1:0][7:0] sums_next;

   gfpe_lanes #(
      .NUM_LANES (NUM_LANES)
   ) u_lanes (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .close     (closing),
      .data_byte (in_byte_ff),
      .sums_next (sums_next)
   );

   assign buf_load.load       = advance && closing;
   assign buf_load.last_index = INDEX_W'(np - 1'b1);

   gfpe_out_buf #(
      .NUM_LANES (NUM_LANES)
   ) u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (buf_load),
      .sums             (sums_next),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_parity_byte  (rsp_parity_byte),
      .rsp_parity_index (rsp_parity_index),
      .rsp_last_parity  (rsp_last_parity),
      .status           (buf_status)
   );

endmodule

/* tb/tb_gf256_erasure_parity_encoder.sv */
// self-checking testbench for gf256_erasure_parity_encoder: directed table, then random phases
// depends on gfpe_pkg and the encoder rtl; holds its own gf(256) parity predictor
module tb_gf256_erasure_parity_encoder;
   import gfpe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DATA      = 16;
   localparam int MAX_PARITY    = 8;
   localparam int PAR_LIMIT     = (MAX_PARITY < RESULT_CAP) ? MAX_PARITY : RESULT_CAP;
   localparam int RST_DATA_CNT  = 16;
   localparam int RST_PAR_CNT   = 4;
   localparam int DRAIN_CYCLES  = 8;     // input register plus lane fold, with margin
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_WORDS   = 45;
   localparam int NUM_ROWS      = 29;

   typedef enum logic {ROW_DATA, ROW_CSR} row_kind_type;

   // one row of the directed table; typed_parity is the parity byte every lane must
   // show when the column is a single byte (p^0 is 1 for every lane)
   typedef struct packed {
      row_kind_type kind;
      logic         csr_sel;
      logic [7:0]   value;
      logic         has_typed;
      logic [7:0]   typed_parity;
   } stim_row_type;

   typedef struct packed {
      logic [7:0]         parity_byte;
      logic [INDEX_W-1:0] parity_index;
      logic               last_parity;
   } parity_word_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // reset config: 16 shards, so two bytes close nothing
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h00, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b0, 8'h00},
      // shard count lowered below the fill: next byte closes, four lanes out
      '{ROW_CSR,  CSR_SHARD_TOTAL, 8'h01, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h80, 1'b0, 8'h00},
      // zero parity count acts as one
      '{ROW_CSR,  CSR_CHECK_TOTAL, 8'h00, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'ha5, 1'b1, 8'ha5},
      // parity count above eight saturates
      '{ROW_CSR,  CSR_CHECK_TOTAL, 8'h0f, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b1, 8'hff},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h00, 1'b1, 8'h00},
      // zero shard count acts as one
      '{ROW_CSR,  CSR_SHARD_TOTAL, 8'h00, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h5a, 1'b1, 8'h5a},
      // shard count above sixteen saturates, parity count changed halfway through
      '{ROW_CSR,  CSR_SHARD_TOTAL, 8'h1f, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h01, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h80, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hfe, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h7f, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h00, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h02, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_CHECK_TOTAL, 8'h03, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h40, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h10, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hc3, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h3c, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h08, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'hff, 1'b0, 8'h00},
      '{ROW_DATA, CSR_SHARD_TOTAL, 8'h20, 1'b0, 8'h00}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_data_byte;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_parity_byte;
   logic [INDEX_W-1:0]     rsp_parity_index;
   logic                   rsp_last_parity;
   logic                   csr_write_en;
   logic                   csr_index;
   logic [SHARD_CNT_W-1:0] csr_wdata;

   // predictor state: mirrored config plus one accumulator and running power per lane
   logic [SHARD_CNT_W-1:0] cfg_shard_total = SHARD_CNT_W'(RST_DATA_CNT);
   logic [PAR_CNT_W-1:0]   cfg_check_total = PAR_CNT_W'(RST_PAR_CNT);
   logic [7:0]             lane_acc [MAX_PARITY];
   logic [7:0]             lane_pow [MAX_PARITY];
   int                     column_fill;
   parity_word_type        column_words [RESULT_CAP];

   parity_word_type        parity_expect_q [$];
   int                     fail_count = 0;
   int                     quiet_cycles = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;

   gf256_erasure_parity_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parity_byte  (rsp_parity_byte),
      .rsp_parity_index (rsp_parity_index),
      .rsp_last_parity  (rsp_last_parity),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // shift-and-add multiply in GF(256); a carry out of bit 7 folds back as 0x1d
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod;
      logic [7:0] shifted;
      prod    = 8'h00;
      shifted = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            prod = prod ^ shifted;
         end
         shifted = shifted[7] ? ({shifted[6:0], 1'b0} ^ 8'h1d) : {shifted[6:0], 1'b0};
      end
      return prod;
   endfunction

   function automatic void clear_lanes();
      for (int p = 0; p < MAX_PARITY; p++) begin
         lane_acc[p] = 8'h00;
         lane_pow[p] = 8'h01;
      end
      column_fill = 0;
   endfunction

   // folds one data word into every lane; on the closing word fills column_words
   // and returns how many parity words the block owes
   function automatic int encode_byte(input logic [7:0] data);
      int shards;
      int lanes_out;
      shards    = (cfg_shard_total == 0) ? 1 :
                  (cfg_shard_total > MAX_DATA) ? MAX_DATA : int'(cfg_shard_total);
      lanes_out = (cfg_check_total == 0) ? 1 :
                  (cfg_check_total > PAR_LIMIT) ? PAR_LIMIT : int'(cfg_check_total);
      for (int p = 0; p < MAX_PARITY; p++) begin
         lane_acc[p] = lane_acc[p] ^ gf_times(data, lane_pow[p]);
         lane_pow[p] = gf_times(lane_pow[p], 8'(p));
      end
      if (column_fill + 1 < shards) begin
         column_fill++;
         return 0;
      end
      for (int p = 0; p < lanes_out; p++) begin
         column_words[p] = '{lane_acc[p], INDEX_W'(p), (p == lanes_out - 1)};
      end
      clear_lanes();
      return lanes_out;
   endfunction

   // ---------------------------------------------------------------- drivers

   // sends one data word, with a random gap first, and books the parity it causes
   task automatic push_byte(input logic [7:0] data, input logic has_typed,
                            input logic [7:0] typed_parity);
      int n_words;
      parity_word_type w;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      n_words = encode_byte(data);
      for (int i = 0; i < n_words; i++) begin
         w = column_words[i];
         if (has_typed) begin
            w.parity_byte = typed_parity;
         end
         parity_expect_q.push_back(w);
      end
   endtask

   // sender goes quiet until every booked parity word is out, then waits extra cycles
   task automatic hold_until_drained(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (parity_expect_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [SHARD_CNT_W-1:0] wdata);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= wdata;
      @(posedge clock);
      if (sel == CSR_SHARD_TOTAL) begin
         cfg_shard_total = wdata;
      end else begin
         cfg_check_total = wdata[PAR_CNT_W-1:0];
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver side

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // every accepted parity word is matched against the oldest booked one
   always @(posedge clock) begin
      parity_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parity_expect_q.size() == 0) begin
            $error("parity word %0h index %0d arrived with none expected",
                   rsp_parity_byte, rsp_parity_index);
            fail_count++;
         end else begin
            want = parity_expect_q.pop_front();
            if (rsp_parity_byte !== want.parity_byte) begin
               $error("parity_byte: expected %0h, got %0h", want.parity_byte, rsp_parity_byte);
               fail_count++;
            end
            if (rsp_parity_index !== want.parity_index) begin
               $error("parity_index: expected %0d, got %0d",
                      want.parity_index, rsp_parity_index);
               fail_count++;
            end
            if (rsp_last_parity !== want.last_parity) begin
               $error("last_parity: expected %0b, got %0b", want.last_parity, rsp_last_parity);
               fail_count++;
            end
         end
      end
   end

   // watchdog: any word moving on either side restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("gf256_erasure_parity_encoder regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [7:0] data;
      int         ds_sel;
      int         ps_sel;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      csr_write_en  = 1'b0;
      csr_index     = CSR_SHARD_TOTAL;
      csr_wdata     = '0;
      clear_lanes();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table; register rows wait for the block to go idle first
      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            hold_until_drained(DRAIN_CYCLES);
            write_reg(DIRECTED_ROWS[r].csr_sel, DIRECTED_ROWS[r].value[SHARD_CNT_W-1:0]);
         end else begin
            push_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].has_typed,
                      DIRECTED_ROWS[r].typed_parity);
         end
      end

      // random phases: the first four pin the register extremes, the rest draw them;
      // phases may end mid-column so the next setting lands on a partial column
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         hold_until_drained(DRAIN_CYCLES);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         case (ph)
            0: begin ds_sel = 1;  ps_sel = 8;  end
            1: begin ds_sel = 16; ps_sel = 1;  end
            2: begin ds_sel = 31; ps_sel = 15; end
            3: begin ds_sel = 0;  ps_sel = 0;  end
            default: begin
               ds_sel = $urandom_range(0, 31);
               ps_sel = $urandom_range(0, 15);
            end
         endcase
         write_reg(CSR_SHARD_TOTAL, SHARD_CNT_W'(ds_sel));
         write_reg(CSR_CHECK_TOTAL, SHARD_CNT_W'(ps_sel));
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // sender backs off until the block has emptied, once per phase
            if (i == PHASE_WORDS / 2) begin
               hold_until_drained(0);
            end
            case ($urandom_range(0, 7))
               0: data = 8'h00;
               1: data = 8'hff;
               2: data = 8'h01 << $urandom_range(0, 7);
               default: data = 8'($urandom_range(0, 255));
            endcase
            push_byte(data, 1'b0, 8'h00);
         end
      end

      hold_until_drained(DRAIN_CYCLES);
      if (fail_count == 0 && parity_expect_q.size() == 0) begin
         $display("gf256_erasure_parity_encoder regression: pass");
      end else begin
         $display("gf256_erasure_parity_encoder regression: fail");
      end
      $finish;
   end

endmodule
